@@ sv/lwsc_pkg.sv @@
// Shared types and constants of the write-back sector cache controller.
// Used by lwsc_ctrl and lru_writeback_sector_cache; no dependencies.
package lwsc_pkg;

   localparam int SLOTS    = 32;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int SECTOR_W = 32;
   localparam int STAMP_W  = 32;
   localparam int COUNT_W  = 32;
   localparam int SLOT_W   = 5;
   localparam int ENTRY_W  = SECTOR_W + STAMP_W;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FLUSH = 2'd2,
      OP_RESET = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_WB   = 2'd0,
      KIND_FILL = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef struct packed {
      op_type                op;
      logic [SECTOR_W-1:0]   sector;
      logic                  full_sector;
      logic [STAMP_W-1:0]    time_now;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [SLOT_W-1:0]     slot;
      logic [SECTOR_W-1:0]   disk_sector;
      logic                  hit;
      logic [COUNT_W-1:0]    hit_count;
      logic [COUNT_W-1:0]    miss_count;
      logic                  last;
   } rsp_type;

   // One slot entry as held in the tag memory.
   typedef struct packed {
      logic [SECTOR_W-1:0]   tag;
      logic [STAMP_W-1:0]    stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_WB,
      ST_FILL,
      ST_DONE,
      ST_FL_FIND,
      ST_FL_WB
   } state_type;

endpackage

@@ sv/lwsc_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lwsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lwsc_ctrl.sv @@
// Request sequencer: slot scan over the tag memory, victim choice, dirty
// tracking and result generation. Depends on lwsc_pkg and lwsc_ram.
module lwsc_ctrl import lwsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_take,
   output logic    res_valid,
   output rsp_type res_data,
   input  logic    res_ready
);

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 found_v_ff, found_v_in;
   logic [IDX_W-1:0]     found_idx_ff, found_idx_in;
   logic                 min_v_ff, min_v_in;
   logic [IDX_W-1:0]     min_idx_ff, min_idx_in;
   logic [STAMP_W-1:0]   min_stamp_ff, min_stamp_in;
   logic [SECTOR_W-1:0]  min_tag_ff, min_tag_in;
   logic [IDX_W-1:0]     serve_ff, serve_in;
   logic                 hit_ff, hit_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [SLOTS-1:0]     dirty_ff, dirty_in;
   logic [COUNT_W-1:0]   hits_ff, hits_in;
   logic [COUNT_W-1:0]   misses_ff, misses_in;

   logic                 ram_wr_en;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic [ENTRY_W-1:0]   ram_rd_data;
   entry_type            rd_entry;
   entry_type            wr_entry;

   logic                 accept;
   logic                 res_load;
   logic                 is_access;
   logic                 need_fill;
   logic                 scan_end;
   logic                 chk_live;
   logic [SLOTS-1:0]     dirty_mask;
   logic                 any_free;
   logic [IDX_W-1:0]     victim;
   logic                 victim_dirty;

   function automatic logic [IDX_W-1:0] first_set(input logic [SLOTS-1:0] m);
      logic [IDX_W-1:0] r;
      r = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = IDX_W'(i);
         end
      end
      return r;
   endfunction

   lwsc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (serve_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry       = ram_rd_data;
   assign wr_entry.tag   = req_ff.sector;
   assign wr_entry.stamp = req_ff.time_now;
   assign ram_wr_data    = wr_entry;

   assign accept       = req_valid & req_take;
   assign res_load     = res_valid & res_ready;
   assign is_access    = req_ff.op inside {OP_READ, OP_WRITE};
   assign need_fill    = !(req_ff.op == OP_WRITE && req_ff.full_sector);
   assign scan_end     = (cnt_ff == CNT_W'(SLOTS));
   assign chk_live     = chk_valid_ff & valid_ff[chk_idx_ff];
   assign dirty_mask   = valid_ff & dirty_ff;
   assign any_free     = ~&valid_ff;
   // Lowest unused slot first, else the oldest stamp seen in the scan.
   assign victim       = any_free ? first_set(~valid_ff) : min_idx_ff;
   assign victim_dirty = valid_ff[victim] & dirty_ff[victim];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op inside {OP_READ, OP_WRITE}) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FL_FIND;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end && !chk_valid_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (found_v_ff) begin
               state_in = ST_DONE;
            end else if (victim_dirty) begin
               state_in = ST_WB;
            end else if (need_fill) begin
               state_in = ST_FILL;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WB: begin
            if (res_load) begin
               state_in = need_fill ? ST_FILL : ST_DONE;
            end
         end
         ST_FILL: begin
            if (res_load) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_load) begin
               state_in = ST_IDLE;
            end
         end
         ST_FL_FIND: begin
            state_in = (dirty_mask == '0) ? ST_DONE : ST_FL_WB;
         end
         ST_FL_WB: begin
            if (res_load) begin
               state_in = ST_FL_FIND;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: memory port, handshake and result
   always_comb begin
      req_take             = (state_ff == ST_IDLE);
      ram_rd_en            = 1'b0;
      ram_rd_addr          = cnt_ff[IDX_W-1:0];
      ram_wr_en            = 1'b0;
      res_valid            = 1'b0;
      res_data.kind        = KIND_DONE;
      res_data.slot        = '0;
      res_data.disk_sector = '0;
      res_data.hit         = 1'b0;
      res_data.hit_count   = hits_ff;
      res_data.miss_count  = misses_ff;
      res_data.last        = 1'b0;
      case (state_ff)
         ST_SCAN: begin
            ram_rd_en = !scan_end;
         end
         ST_WB: begin
            res_valid            = 1'b1;
            res_data.kind        = KIND_WB;
            res_data.slot        = SLOT_W'(serve_ff);
            res_data.disk_sector = min_tag_ff;
         end
         ST_FILL: begin
            res_valid            = 1'b1;
            res_data.kind        = KIND_FILL;
            res_data.slot        = SLOT_W'(serve_ff);
            res_data.disk_sector = req_ff.sector;
         end
         ST_DONE: begin
            res_valid     = 1'b1;
            res_data.kind = KIND_DONE;
            res_data.last = 1'b1;
            if (is_access) begin
               res_data.slot        = SLOT_W'(serve_ff);
               res_data.disk_sector = req_ff.sector;
               res_data.hit         = hit_ff;
               ram_wr_en            = res_load;
            end
         end
         ST_FL_FIND: begin
            ram_rd_en   = (dirty_mask != '0);
            ram_rd_addr = first_set(dirty_mask);
         end
         ST_FL_WB: begin
            res_valid            = 1'b1;
            res_data.kind        = KIND_WB;
            res_data.slot        = SLOT_W'(serve_ff);
            res_data.disk_sector = rd_entry.tag;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      req_in       = req_ff;
      cnt_in       = cnt_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      found_v_in   = found_v_ff;
      found_idx_in = found_idx_ff;
      min_v_in     = min_v_ff;
      min_idx_in   = min_idx_ff;
      min_stamp_in = min_stamp_ff;
      min_tag_in   = min_tag_ff;
      serve_in     = serve_ff;
      hit_in       = hit_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in     = req_data;
               cnt_in     = '0;
               found_v_in = 1'b0;
               min_v_in   = 1'b0;
            end
         end
         ST_SCAN: begin
            if (!scan_end) begin
               cnt_in       = cnt_ff + CNT_W'(1);
               chk_valid_in = 1'b1;
               chk_idx_in   = cnt_ff[IDX_W-1:0];
            end
            // Check the entry read in the previous cycle
            if (chk_live) begin
               if (!found_v_ff && rd_entry.tag == req_ff.sector) begin
                  found_v_in   = 1'b1;
                  found_idx_in = chk_idx_ff;
               end
               if (!min_v_ff || rd_entry.stamp < min_stamp_ff) begin
                  min_v_in     = 1'b1;
                  min_idx_in   = chk_idx_ff;
                  min_stamp_in = rd_entry.stamp;
                  min_tag_in   = rd_entry.tag;
               end
            end
         end
         ST_DECIDE: begin
            hit_in = found_v_ff;
            if (found_v_ff) begin
               serve_in = found_idx_ff;
               if (hits_ff != '1) begin
                  hits_in = hits_ff + COUNT_W'(1);
               end
            end else begin
               serve_in = victim;
               if (misses_ff != '1) begin
                  misses_in = misses_ff + COUNT_W'(1);
               end
            end
         end
         ST_WB: begin
            if (res_load) begin
               dirty_in[serve_ff] = 1'b0;
            end
         end
         ST_DONE: begin
            if (res_load && is_access) begin
               valid_in[serve_ff] = 1'b1;
               if (req_ff.op == OP_WRITE) begin
                  dirty_in[serve_ff] = 1'b1;
               end
            end
         end
         ST_FL_FIND: begin
            if (dirty_mask != '0) begin
               serve_in = first_set(dirty_mask);
            end else if (req_ff.op == OP_RESET) begin
               // Invalidate and zero the counts before done goes out
               valid_in  = '0;
               dirty_in  = '0;
               hits_in   = '0;
               misses_in = '0;
            end
         end
         ST_FL_WB: begin
            if (res_load) begin
               dirty_in[serve_ff] = 1'b0;
            end
         end
         default: begin
            serve_in = serve_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_valid_ff <= 1'b0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      cnt_ff       <= cnt_in;
      chk_idx_ff   <= chk_idx_in;
      found_v_ff   <= found_v_in;
      found_idx_ff <= found_idx_in;
      min_v_ff     <= min_v_in;
      min_idx_ff   <= min_idx_in;
      min_stamp_ff <= min_stamp_in;
      min_tag_ff   <= min_tag_in;
      serve_ff     <= serve_in;
      hit_ff       <= hit_in;
   end

endmodule

@@ sv/lru_writeback_sector_cache.sv @@
// Top level of the write-back sector cache controller: sequencer and
// output register. Depends on lwsc_pkg and lwsc_ctrl.
//
// Usage:
//   The request channel (req_valid, req_stall, req_data) takes read, write,
//   flush-all and reset-cache requests. A request is taken only while the
//   block is idle; req_stall is high while one is in progress.
//   The result channel (rsp_valid, rsp_stall, rsp_data) carries writeback
//   and fill commands, then one done result with last set.
//   A read or write walks every tag memory entry, one read per cycle, and
//   then issues each writeback or fill that it causes. A flush or reset
//   writes back every dirty slot in turn, lowest index first.
//   Results pass through one output register; a stall on rsp_stall holds
//   that register and the sequencer waits until it frees up.
//   Reset clears all valid and dirty marks and both counters at once; no
//   clearing pass is needed, and the first request can follow right after.
module lru_writeback_sector_cache import lwsc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    req_take;
   logic    res_valid;
   rsp_type res_data;
   logic    res_ready;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   lwsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_take  (req_take),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready)
   );

   // Load a new result when the register is empty or being drained
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = !req_take;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
